### hdl/fbc_pkg.sv
package fbc_pkg;

   localparam int PLANE_COUNT = 6;
   localparam int PIDX_W      = $clog2(PLANE_COUNT);
   localparam int COORD_W     = 16;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int CROSS_W     = 2 * DIFF_W;
   localparam int NORM_W      = CROSS_W + 1;
   localparam int OFFSET_W    = COORD_W + NORM_W + 3;
   localparam int SUM_W       = OFFSET_W + 1;
   localparam int MUL_A_W     = DIFF_W;
   localparam int MUL_B_W     = NORM_W;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;

   localparam logic REQ_SET_PLANE = 1'b0;
   localparam logic REQ_CORNER    = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic signed [NORM_W-1:0]   nx;
      logic signed [NORM_W-1:0]   ny;
      logic signed [NORM_W-1:0]   nz;
      logic signed [OFFSET_W-1:0] d;
   } plane_type;

   typedef struct packed {
      logic              en;
      logic [PIDX_W-1:0] addr;
      plane_type         data;
   } plane_wr_type;

   typedef struct packed {
      logic signed [MUL_A_W-1:0] a0;
      logic signed [MUL_A_W-1:0] a1;
      logic signed [MUL_A_W-1:0] a2;
      logic signed [MUL_B_W-1:0] b0;
      logic signed [MUL_B_W-1:0] b1;
      logic signed [MUL_B_W-1:0] b2;
   } mul_op_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] p0;
      logic signed [PROD_W-1:0] p1;
      logic signed [PROD_W-1:0] p2;
   } mul_prod_type;

endpackage

### hdl/fbc_if.sv
interface fbc_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [2:0] plane_index;
   logic signed [15:0] ax;
   logic signed [15:0] ay;
   logic signed [15:0] az;
   logic signed [15:0] bx;
   logic signed [15:0] by;
   logic signed [15:0] bz;
   logic signed [15:0] cx;
   logic signed [15:0] cy;
   logic signed [15:0] cz;
   logic       last_corner;

   modport source (output valid, req_type, plane_index, ax, ay, az, bx, by, bz,
                   cx, cy, cz, last_corner, input ready);
   modport sink (input valid, req_type, plane_index, ax, ay, az, bx, by, bz,
                 cx, cy, cz, last_corner, output ready);
endinterface

interface fbc_rsp_if;
   logic       valid;
   logic       ready;
   logic       culled;
   logic [2:0] culling_plane;

   modport source (output valid, culled, culling_plane, input ready);
   modport sink (input valid, culled, culling_plane, output ready);
endinterface

### hdl/fbc_plane_mem.sv
module fbc_plane_mem import fbc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  plane_wr_type      wr,
   input  logic [PIDX_W-1:0] rd_addr,
   output plane_type         rd_data
);

   plane_type                mem [PLANE_COUNT];
   plane_type                rd_raw_ff;
   logic                     rd_valid_ff;
   logic                     rd_valid_in;
   logic [PLANE_COUNT-1:0]   valid_ff;
   logic [PLANE_COUNT-1:0]   valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
      rd_valid_in = valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_raw_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // entries never written read as the zero plane
   assign rd_data = rd_valid_ff ? rd_raw_ff : '0;

endmodule

### hdl/fbc_mul3.sv
module fbc_mul3 import fbc_pkg::*; (
   input  logic         clock,
   input  mul_op_type   op,
   output mul_prod_type prod
);

   mul_prod_type prod_ff;
   mul_prod_type prod_in;

   always_comb begin
      prod_in.p0 = op.a0 * op.b0;
      prod_in.p1 = op.a1 * op.b1;
      prod_in.p2 = op.a2 * op.b2;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### hdl/frustum_box_culling.sv
// Six-plane box culler. A plane item (req_type 0) stores the plane through points a, b, c
// in entry plane_index; indexes 6 and 7 are dropped. A corner item (req_type 1) tests point a
// against all six planes; the item with last_corner set yields one result: culled and the
// lowest plane that had every corner of the box outside. Ready is high only when idle, so
// an item is finished before the next is accepted; a last corner also waits for the result
// register to empty. The pace is set by the three shared multipliers, which build the cross
// product in two passes and the offset in a third, and by the single read port of the plane
// memory, which is swept one plane per cycle for each corner.
module frustum_box_culling import fbc_pkg::*; (
   input logic       clock,
   input logic       reset,
   fbc_req_if.sink   req,
   fbc_rsp_if.source rsp
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_DIFF   = 10'b00_0000_0010,
      ST_CRS1   = 10'b00_0000_0100,
      ST_CRS2   = 10'b00_0000_1000,
      ST_NORM   = 10'b00_0001_0000,
      ST_OFS    = 10'b00_0010_0000,
      ST_WRITE  = 10'b00_0100_0000,
      ST_SWEEP  = 10'b00_1000_0000,
      ST_DRAIN  = 10'b01_0000_0000,
      ST_FINISH = 10'b10_0000_0000
   } state_type;

   localparam logic [PIDX_W-1:0] LAST_PLANE = PIDX_W'(PLANE_COUNT - 1);

   state_type state_ff, state_in;

   coord_type a_ff [3], a_in [3];
   coord_type b_ff [3], b_in [3];
   coord_type c_ff [3], c_in [3];
   logic      last_ff, last_in;
   logic [PIDX_W-1:0] pidx_ff, pidx_in;

   logic signed [DIFF_W-1:0]  u_ff [3], u_in [3];
   logic signed [DIFF_W-1:0]  v_ff [3], v_in [3];
   logic signed [CROSS_W-1:0] part_ff [3], part_in [3];
   logic signed [NORM_W-1:0]  n_ff [3], n_in [3];
   logic signed [OFFSET_W-1:0] d_ff, d_in;

   logic [PIDX_W-1:0] cnt_ff, cnt_in;
   logic              s1_ff, s1_in, s2_ff, s2_in;
   logic [PIDX_W-1:0] s1_idx_ff, s1_idx_in, s2_idx_ff, s2_idx_in;
   logic [PLANE_COUNT-1:0] flags_ff, flags_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              culled_ff, culled_in;
   logic [2:0]        plane_ff, plane_in;

   logic              req_take;
   logic              rsp_free;
   logic              outside;
   logic [2:0]        lowest;
   logic signed [CROSS_W-1:0]  prod_lo [3];
   logic signed [OFFSET_W-1:0] ofs_sum;
   logic signed [SUM_W-1:0]    test_sum;

   mul_op_type   mul_op;
   mul_prod_type mul_prod;
   plane_wr_type wr;
   plane_type    rd_data;
   logic [PIDX_W-1:0] rd_addr;

   fbc_plane_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fbc_mul3 u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (mul_prod)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign req_take  = req.valid && req.ready;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   assign prod_lo[0] = mul_prod.p0[CROSS_W-1:0];
   assign prod_lo[1] = mul_prod.p1[CROSS_W-1:0];
   assign prod_lo[2] = mul_prod.p2[CROSS_W-1:0];

   assign ofs_sum  = OFFSET_W'(mul_prod.p0) + OFFSET_W'(mul_prod.p1)
                   + OFFSET_W'(mul_prod.p2);
   assign test_sum = SUM_W'(mul_prod.p0) + SUM_W'(mul_prod.p1)
                   + SUM_W'(mul_prod.p2) + SUM_W'(d_ff);
   assign outside  = test_sum[SUM_W-1];

   assign rd_addr = cnt_ff;

   assign wr.en      = (state_ff == ST_WRITE);
   assign wr.addr    = pidx_ff;
   assign wr.data.nx = n_ff[0];
   assign wr.data.ny = n_ff[1];
   assign wr.data.nz = n_ff[2];
   assign wr.data.d  = -ofs_sum;

   // shared multiplier operands
   always_comb begin
      mul_op = '0;
      if (s1_ff) begin
         mul_op.a0 = MUL_A_W'(a_ff[0]);
         mul_op.a1 = MUL_A_W'(a_ff[1]);
         mul_op.a2 = MUL_A_W'(a_ff[2]);
         mul_op.b0 = rd_data.nx;
         mul_op.b1 = rd_data.ny;
         mul_op.b2 = rd_data.nz;
      end else begin
         unique case (state_ff)
            ST_CRS1: begin
               mul_op.a0 = u_ff[1];
               mul_op.b0 = MUL_B_W'(v_ff[2]);
               mul_op.a1 = u_ff[2];
               mul_op.b1 = MUL_B_W'(v_ff[0]);
               mul_op.a2 = u_ff[0];
               mul_op.b2 = MUL_B_W'(v_ff[1]);
            end
            ST_CRS2: begin
               mul_op.a0 = u_ff[2];
               mul_op.b0 = MUL_B_W'(v_ff[1]);
               mul_op.a1 = u_ff[0];
               mul_op.b1 = MUL_B_W'(v_ff[2]);
               mul_op.a2 = u_ff[1];
               mul_op.b2 = MUL_B_W'(v_ff[0]);
            end
            ST_OFS: begin
               mul_op.a0 = MUL_A_W'(a_ff[0]);
               mul_op.a1 = MUL_A_W'(a_ff[1]);
               mul_op.a2 = MUL_A_W'(a_ff[2]);
               mul_op.b0 = n_ff[0];
               mul_op.b1 = n_ff[1];
               mul_op.b2 = n_ff[2];
            end
            default: begin
               mul_op = '0;
            end
         endcase
      end
   end

   always_comb begin
      lowest = '0;
      for (int i = PLANE_COUNT - 1; i >= 0; i--) begin
         if (flags_ff[i]) begin
            lowest = 3'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      last_in      = last_ff;
      pidx_in      = pidx_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      part_in      = part_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      cnt_in       = cnt_ff;
      s1_in        = 1'b0;
      s1_idx_in    = cnt_ff;
      s2_in        = s1_ff;
      s2_idx_in    = s1_idx_ff;
      flags_in     = flags_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      culled_in    = culled_ff;
      plane_in     = plane_ff;

      if (s1_ff) begin
         d_in = rd_data.d;
      end
      if (s2_ff && !outside) begin
         flags_in[s2_idx_ff] = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               a_in    = '{req.ax, req.ay, req.az};
               b_in    = '{req.bx, req.by, req.bz};
               c_in    = '{req.cx, req.cy, req.cz};
               last_in = req.last_corner;
               pidx_in = PIDX_W'(req.plane_index);
               cnt_in  = '0;
               if (req.req_type == REQ_CORNER) begin
                  state_in = ST_SWEEP;
               end else if (int'(req.plane_index) < PLANE_COUNT) begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               u_in[i] = DIFF_W'(b_ff[i]) - DIFF_W'(a_ff[i]);
               v_in[i] = DIFF_W'(c_ff[i]) - DIFF_W'(a_ff[i]);
            end
            state_in = ST_CRS1;
         end
         ST_CRS1: begin
            state_in = ST_CRS2;
         end
         ST_CRS2: begin
            part_in  = prod_lo;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            for (int i = 0; i < 3; i++) begin
               n_in[i] = NORM_W'(part_ff[i]) - NORM_W'(prod_lo[i]);
            end
            state_in = ST_OFS;
         end
         ST_OFS: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            s1_in = 1'b1;
            if (cnt_ff == LAST_PLANE) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (s2_ff && s2_idx_ff == LAST_PLANE) begin
               state_in = last_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               culled_in    = |flags_ff;
               plane_in     = lowest;
               flags_in     = '1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      last_ff   <= last_in;
      pidx_ff   <= pidx_in;
      u_ff      <= u_in;
      v_ff      <= v_in;
      part_ff   <= part_in;
      n_ff      <= n_in;
      d_ff      <= d_in;
      s1_idx_ff <= s1_idx_in;
      s2_idx_ff <= s2_idx_in;
      culled_ff <= culled_in;
      plane_ff  <= plane_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         flags_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.culled        = culled_ff;
   assign rsp.culling_plane = plane_ff;

   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_sweep_pipe: assert property (@(posedge clock) disable iff (reset)
      s2_ff |-> (state_ff == ST_SWEEP || state_ff == ST_DRAIN))
      else $error("plane test outside a corner sweep");

   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> last_ff)
      else $error("result built for a corner that is not the last");

   a_flags_rearm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_free) |=> flags_ff == '1)
      else $error("flags not set again after a result");

   a_no_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      s1_ff |-> !wr.en)
      else $error("plane write during a corner sweep");

endmodule
